/* src/cepl_pkg.sv */
package cepl_pkg;

    // Field and datapath widths.
    localparam int POS_W      = 17;
    localparam int DIFF_W     = 18;
    localparam int MAG_W      = 17;
    localparam int ERR_W      = 53;
    localparam int DER_W      = 54;
    localparam int SUM_W      = 64;
    localparam int GAIN_W     = 32;
    localparam int BAND_W     = 16;
    localparam int DRIVE_W    = 32;
    localparam int MUL_W      = 35;
    localparam int PROD_W     = 70;
    localparam int PART_W     = 64;
    localparam int ACC_W      = 100;
    localparam int FRAC_DROP  = 8;
    localparam int STEP_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P,
        CFG_GAIN_I,
        CFG_GAIN_D,
        CFG_FWD_TARGET,
        CFG_BACK_TARGET,
        CFG_RESET_BAND
    } cfg_idx_t;

    // Reset values of the configuration registers.
    localparam logic signed [GAIN_W-1:0] GAIN_P_RST      = 32'sd156036;
    localparam logic signed [GAIN_W-1:0] GAIN_I_RST      = 32'sd0;
    localparam logic signed [GAIN_W-1:0] GAIN_D_RST      = 32'sd0;
    localparam logic signed [POS_W-1:0]  FWD_TARGET_RST  = 17'sd800;
    localparam logic signed [POS_W-1:0]  BACK_TARGET_RST = 17'sd0;
    localparam logic [BAND_W-1:0]        RESET_BAND_RST  = 16'd5;

    // Multiplier operand selects.
    typedef enum logic [1:0] {
        A_AD,
        A_GP,
        A_GD,
        A_GI
    } asel_t;

    typedef enum logic [2:0] {
        B_AD,
        B_SQ,
        B_ERR_LO,
        B_ERR_HI,
        B_DER_LO,
        B_DER_HI,
        B_SUM_LO,
        B_SUM_HI
    } bsel_t;

    // Datapath operations on the registered product and the accumulator.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_ERR,
        OP_STATE,
        OP_ACC_LO,
        OP_ACC_HI,
        OP_NEG,
        OP_OUT
    } op_t;

    // One control word of the microprogram.
    typedef struct packed {
        asel_t             a_sel;
        bsel_t             b_sel;
        op_t               op;
        logic              jump_hold;
        logic [STEP_W-1:0] jump_to;
        logic              done;
    } ctrl_word_t;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic signed [POS_W-1:0]  forward_target;
        logic signed [POS_W-1:0]  back_target;
        logic [BAND_W-1:0]        reset_band;
    } cfg_regs_t;

    // Result word fields.
    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic               drive_saturated;
        logic               coast_stop;
    } result_t;

    localparam logic [STEP_W-1:0] STEP_OUT  = 4'd12;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_OUT;

    localparam ctrl_word_t UC_NOP = '{
        a_sel:     A_AD,
        b_sel:     B_AD,
        op:        OP_NONE,
        jump_hold: 1'b0,
        jump_to:   '0,
        done:      1'b0
    };

    // Microprogram: the cube on the shared multiplier, the state update, then
    // the three gain products in 32-bit halves, negation and the output step.
    function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
        ctrl_word_t w;
        w = UC_NOP;
        case (step)
            4'd0: begin
                w.a_sel = A_AD;
                w.b_sel = B_AD;
            end
            4'd1: begin
                w.a_sel = A_AD;
                w.b_sel = B_SQ;
            end
            4'd2: begin
                w.op = OP_ERR;
            end
            4'd3: begin
                w.op        = OP_STATE;
                w.jump_hold = 1'b1;
                w.jump_to   = STEP_OUT;
            end
            4'd4: begin
                w.a_sel = A_GP;
                w.b_sel = B_ERR_LO;
            end
            4'd5: begin
                w.a_sel = A_GP;
                w.b_sel = B_ERR_HI;
                w.op    = OP_ACC_LO;
            end
            4'd6: begin
                w.a_sel = A_GD;
                w.b_sel = B_DER_LO;
                w.op    = OP_ACC_HI;
            end
            4'd7: begin
                w.a_sel = A_GD;
                w.b_sel = B_DER_HI;
                w.op    = OP_ACC_LO;
            end
            4'd8: begin
                w.a_sel = A_GI;
                w.b_sel = B_SUM_LO;
                w.op    = OP_ACC_HI;
            end
            4'd9: begin
                w.a_sel = A_GI;
                w.b_sel = B_SUM_HI;
                w.op    = OP_ACC_LO;
            end
            4'd10: begin
                w.op = OP_ACC_HI;
            end
            4'd11: begin
                w.op = OP_NEG;
            end
            4'd12: begin
                w.op   = OP_OUT;
                w.done = 1'b1;
            end
            default: begin
                w = UC_NOP;
            end
        endcase
        return w;
    endfunction

endpackage

/* src/cubic_error_pid_position_loop.sv */
// Position loop with a cubic error term, an integral reset band and a
// saturating, reversed drive output.
// Input stream: s_tdata carries the position in degrees, s_tuser the
// forward and back button flags. Output stream: m_tdata carries the drive in
// Q16.16 volts, m_tuser the saturation and coast-stop flags. Each accepted
// word yields exactly one result word.
// Gains, targets and the reset band are written through cfg_we, cfg_addr and
// cfg_wdata; the user must write them only while the block is idle, which the
// block itself does not enforce. Writes to unused indexes are ignored.
// A microprogram of 13 steps runs on one shared 35 x 35 multiplier, which
// forms the cube and the six half-width gain products. A new word is taken
// only after the program has finished with the last one. In coast-stop mode
// the program jumps over the gain products.
// The result sits in an output register; if the receiver stalls, the next
// word is still accepted and computed, and the sequencer waits in its last
// step until the register is free.
// Reset (aresetn low, synchronous) restores the register defaults, clears
// the previous error and the integral, and empties the output register.
module cubic_error_pid_position_loop (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port.
    input  logic                               cfg_we,
    input  logic [cepl_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [cepl_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // Input stream.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [23:0]                        s_tdata,   // [16:0] position
    input  logic [1:0]                         s_tuser,   // [0] forward_pressed, [1] back_pressed
    // Result stream.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [31:0]                        m_tdata,   // [31:0] drive
    output logic [1:0]                         m_tuser    // [0] drive_saturated, [1] coast_stop
);

    cepl_pkg::cfg_regs_t    cfg_reg;
    cepl_pkg::ctrl_word_t   cw;
    cepl_pkg::result_t      res;

    logic                   accept;
    logic                   busy;
    logic                   done;
    logic                   hold;
    logic                   out_block;

    logic                   m_tvalid_reg;
    logic [31:0]            m_tdata_reg;
    logic [1:0]             m_tuser_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p         <= cepl_pkg::GAIN_P_RST;
            cfg_reg.gain_i         <= cepl_pkg::GAIN_I_RST;
            cfg_reg.gain_d         <= cepl_pkg::GAIN_D_RST;
            cfg_reg.forward_target <= cepl_pkg::FWD_TARGET_RST;
            cfg_reg.back_target    <= cepl_pkg::BACK_TARGET_RST;
            cfg_reg.reset_band     <= cepl_pkg::RESET_BAND_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                cepl_pkg::CFG_GAIN_P:      cfg_reg.gain_p         <= cfg_wdata;
                cepl_pkg::CFG_GAIN_I:      cfg_reg.gain_i         <= cfg_wdata;
                cepl_pkg::CFG_GAIN_D:      cfg_reg.gain_d         <= cfg_wdata;
                cepl_pkg::CFG_FWD_TARGET:  cfg_reg.forward_target <= cfg_wdata[16:0];
                cepl_pkg::CFG_BACK_TARGET: cfg_reg.back_target    <= cfg_wdata[16:0];
                cepl_pkg::CFG_RESET_BAND:  cfg_reg.reset_band     <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Input handshake: one word at a time through the program.
    assign s_tready  = !busy;
    assign accept    = s_tvalid && s_tready;
    assign out_block = m_tvalid_reg && !m_tready;

    cepl_sequencer u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .hold      (hold),
        .out_block (out_block),
        .cw        (cw),
        .busy      (busy),
        .done      (done)
    );

    cepl_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (accept),
        .in_position (s_tdata[16:0]),
        .in_forward  (s_tuser[0]),
        .in_back     (s_tuser[1]),
        .cfg         (cfg_reg),
        .cw          (cw),
        .hold        (hold),
        .res         (res)
    );

    // Output register: loaded at the last step, emptied when the word is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            m_tdata_reg <= res.drive;
            m_tuser_reg <= {res.coast_stop, res.drive_saturated};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* src/cepl_datapath.sv */
module cepl_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  logic signed [16:0]           in_position,
    input  logic                         in_forward,
    input  logic                         in_back,
    input  cepl_pkg::cfg_regs_t          cfg,
    input  cepl_pkg::ctrl_word_t         cw,
    output logic                         hold,
    output cepl_pkg::result_t            res
);

    logic signed [cepl_pkg::POS_W-1:0]   target;
    logic signed [cepl_pkg::DIFF_W-1:0]  diff;
    logic [cepl_pkg::DIFF_W-1:0]         diff_abs;

    logic [cepl_pkg::MAG_W-1:0]          ad_reg;
    logic                                neg_reg;
    logic                                hold_reg;

    logic signed [cepl_pkg::MUL_W-1:0]   mul_a;
    logic signed [cepl_pkg::MUL_W-1:0]   mul_b;
    logic signed [cepl_pkg::PROD_W-1:0]  prod;
    logic signed [cepl_pkg::PART_W-1:0]  p_reg;

    logic signed [cepl_pkg::ERR_W-1:0]   err_reg;
    logic signed [cepl_pkg::ERR_W-1:0]   err_next;
    logic signed [cepl_pkg::ERR_W-1:0]   last_err_reg;
    logic signed [cepl_pkg::DER_W-1:0]   der_reg;
    logic signed [cepl_pkg::SUM_W-1:0]   esum_reg;
    logic signed [cepl_pkg::SUM_W-1:0]   esum_next;
    logic signed [cepl_pkg::ACC_W-1:0]   acc_reg;

    logic [cepl_pkg::SUM_W-1:0]          err_wide;
    logic [cepl_pkg::SUM_W-1:0]          der_wide;
    logic [cepl_pkg::SUM_W:0]            sum_ext;
    logic                                band_clear;

    logic [cepl_pkg::ACC_W-cepl_pkg::FRAC_DROP-1:0] shifted;
    logic                                fits;

    // Target selection and the position difference, taken when a word is accepted.
    always_comb begin
        if (in_forward) begin
            target = cfg.forward_target;
        end else if (in_back) begin
            target = cfg.back_target;
        end else begin
            target = in_position;
        end
        diff     = {in_position[cepl_pkg::POS_W-1], in_position}
                 - {target[cepl_pkg::POS_W-1], target};
        diff_abs = diff[cepl_pkg::DIFF_W-1] ? (cepl_pkg::DIFF_W'(0) - diff) : diff;
    end

    // Sign-extended operands split into 32-bit halves for the multiplier.
    assign err_wide = {{(cepl_pkg::SUM_W-cepl_pkg::ERR_W){err_reg[cepl_pkg::ERR_W-1]}}, err_reg};
    assign der_wide = {{(cepl_pkg::SUM_W-cepl_pkg::DER_W){der_reg[cepl_pkg::DER_W-1]}}, der_reg};

    // Operand selection for the shared signed multiplier.
    always_comb begin
        case (cw.a_sel)
            cepl_pkg::A_AD: mul_a = {{(cepl_pkg::MUL_W-cepl_pkg::MAG_W){1'b0}}, ad_reg};
            cepl_pkg::A_GP: mul_a = {{3{cfg.gain_p[31]}}, cfg.gain_p};
            cepl_pkg::A_GD: mul_a = {{3{cfg.gain_d[31]}}, cfg.gain_d};
            cepl_pkg::A_GI: mul_a = {{3{cfg.gain_i[31]}}, cfg.gain_i};
            default:        mul_a = '0;
        endcase
        case (cw.b_sel)
            cepl_pkg::B_AD:     mul_b = {{(cepl_pkg::MUL_W-cepl_pkg::MAG_W){1'b0}}, ad_reg};
            cepl_pkg::B_SQ:     mul_b = {1'b0, p_reg[33:0]};
            cepl_pkg::B_ERR_LO: mul_b = {3'b000, err_wide[31:0]};
            cepl_pkg::B_ERR_HI: mul_b = {{3{err_wide[63]}}, err_wide[63:32]};
            cepl_pkg::B_DER_LO: mul_b = {3'b000, der_wide[31:0]};
            cepl_pkg::B_DER_HI: mul_b = {{3{der_wide[63]}}, der_wide[63:32]};
            cepl_pkg::B_SUM_LO: mul_b = {3'b000, esum_reg[31:0]};
            cepl_pkg::B_SUM_HI: mul_b = {{3{esum_reg[63]}}, esum_reg[63:32]};
            default:            mul_b = '0;
        endcase
    end

    assign prod = mul_a * mul_b;

    // Signed cube from the registered magnitude cube.
    assign err_next = neg_reg ? (cepl_pkg::ERR_W'(0) - $signed(p_reg[cepl_pkg::ERR_W-1:0]))
                              : $signed(p_reg[cepl_pkg::ERR_W-1:0]);

    // Integral: cleared inside the band, otherwise a saturating add.
    assign band_clear = ad_reg < {1'b0, cfg.reset_band};
    assign sum_ext    = {esum_reg[cepl_pkg::SUM_W-1], esum_reg}
                      + {err_wide[cepl_pkg::SUM_W-1], err_wide};

    always_comb begin
        if (band_clear) begin
            esum_next = '0;
        end else if (sum_ext[cepl_pkg::SUM_W] != sum_ext[cepl_pkg::SUM_W-1]) begin
            esum_next = sum_ext[cepl_pkg::SUM_W] ? {1'b1, {(cepl_pkg::SUM_W-1){1'b0}}}
                                                 : {1'b0, {(cepl_pkg::SUM_W-1){1'b1}}};
        end else begin
            esum_next = sum_ext[cepl_pkg::SUM_W-1:0];
        end
    end

    // Loop state that survives between ticks.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_err_reg <= '0;
            esum_reg     <= '0;
        end else if (cw.op == cepl_pkg::OP_STATE) begin
            last_err_reg <= err_reg;
            esum_reg     <= esum_next;
        end
    end

    // Working registers of one tick.
    always_ff @(posedge aclk) begin
        p_reg <= prod[cepl_pkg::PART_W-1:0];
        if (load) begin
            ad_reg   <= diff_abs[cepl_pkg::MAG_W-1:0];
            neg_reg  <= diff[cepl_pkg::DIFF_W-1];
            hold_reg <= !in_forward && !in_back;
        end
        case (cw.op)
            cepl_pkg::OP_ERR: begin
                err_reg <= err_next;
            end
            cepl_pkg::OP_STATE: begin
                der_reg <= {err_reg[cepl_pkg::ERR_W-1], err_reg}
                         - {last_err_reg[cepl_pkg::ERR_W-1], last_err_reg};
                acc_reg <= '0;
            end
            cepl_pkg::OP_ACC_LO: begin
                acc_reg <= acc_reg + {{(cepl_pkg::ACC_W-cepl_pkg::PART_W){p_reg[63]}}, p_reg};
            end
            cepl_pkg::OP_ACC_HI: begin
                acc_reg <= acc_reg
                         + {{(cepl_pkg::ACC_W-cepl_pkg::PART_W-32){p_reg[63]}}, p_reg, 32'b0};
            end
            cepl_pkg::OP_NEG: begin
                acc_reg <= cepl_pkg::ACC_W'(0) - acc_reg;
            end
            default: begin
            end
        endcase
    end

    // Floor to Q16.16 and clamp to the drive range.
    assign shifted = acc_reg[cepl_pkg::ACC_W-1:cepl_pkg::FRAC_DROP];
    assign fits    = (&shifted[cepl_pkg::ACC_W-cepl_pkg::FRAC_DROP-1:31])
                  || !(|shifted[cepl_pkg::ACC_W-cepl_pkg::FRAC_DROP-1:31]);

    always_comb begin
        if (hold_reg) begin
            res.drive = '0;
        end else if (fits) begin
            res.drive = shifted[cepl_pkg::DRIVE_W-1:0];
        end else if (shifted[cepl_pkg::ACC_W-cepl_pkg::FRAC_DROP-1]) begin
            res.drive = 32'h8000_0000;
        end else begin
            res.drive = 32'h7FFF_FFFF;
        end
        res.drive_saturated = !hold_reg && !fits;
        res.coast_stop      = hold_reg;
    end

    assign hold = hold_reg;

endmodule

/* src/cepl_sequencer.sv */
module cepl_sequencer (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic                  hold,
    input  logic                  out_block,
    output cepl_pkg::ctrl_word_t  cw,
    output logic                  busy,
    output logic                  done
);

    logic                          busy_reg;
    logic [cepl_pkg::STEP_W-1:0]   step_reg;
    cepl_pkg::ctrl_word_t          rom_word;

    // Control word of the current step; idle steps issue no operation.
    assign rom_word = cepl_pkg::ucode(step_reg);
    assign cw       = busy_reg ? rom_word : cepl_pkg::UC_NOP;
    assign done     = busy_reg && rom_word.done && !out_block;
    assign busy     = busy_reg;

    // Step counter with the hold-mode jump; the last step waits for the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (!busy_reg) begin
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
        end else if (rom_word.done) begin
            if (!out_block) begin
                busy_reg <= 1'b0;
            end
        end else if (rom_word.jump_hold && hold) begin
            step_reg <= rom_word.jump_to;
        end else begin
            step_reg <= step_reg + cepl_pkg::STEP_W'(1);
        end
    end

    a_start_enters_first_step: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg && (step_reg == '0))
        else $error("accepted word did not start the program at its first step");

    a_first_step_only_after_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && (step_reg == '0)) |-> $past(start))
        else $error("program reached its first step without an accepted word");

    a_step_in_program: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (step_reg <= cepl_pkg::LAST_STEP))
        else $error("step counter ran past the end of the program");

    a_done_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> !busy_reg)
        else $error("sequencer stayed busy after handing over a result");

endmodule
